### rtl/spf_pkg.sv
// Shared constants and inter-module types of the serial packet framer.
`default_nettype none
package spf_pkg;

	localparam int MAX_BYTES_DEF = 64;
	localparam int PTR_W         = 6;
	localparam int LEN_W         = 7;
	localparam int IN_DATA_W     = 40;
	localparam int OUT_DATA_W    = 16;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 16;

	localparam logic [15:0] DEFAULT_GAP = 16'd20;

	localparam logic [1:0] MODE_TIMEOUT = 2'd0;
	localparam logic [1:0] MODE_DELIM   = 2'd1;
	localparam logic [1:0] MODE_LENGTH  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAP    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DELIM  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd3;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_POLL = 1'b1;

	// A finished packet handed from the front end to the drain side.
	typedef struct packed {
		logic             valid;
		logic             bank;
		logic [LEN_W-1:0] len;
	} push_t;

	// Byte write into the packet buffer.
	typedef struct packed {
		logic             en;
		logic             bank;
		logic [PTR_W-1:0] idx;
		logic [7:0]       data;
	} wr_t;

endpackage
`default_nettype wire

### rtl/serial_packet_framer.sv
// Top level of the serial packet framer: front end, packet drain and their connection.
//
// The block collects received bytes into packets under one of three framing rules
// (inter-byte timeout, delimiter byte, or a length byte at a set offset) and sends
// each finished packet out as a run of byte transactions, tlast on the final byte.
// Input transactions carry either a received byte or an idle poll (tuser), with the
// current millisecond time. Configuration is written through cfg_wr_en, cfg_index
// and cfg_wdata; the user must write it only while the block is idle, as the block
// itself does not enforce it; any write drops the bytes buffered so far. An input
// transaction passes the front end's accept and execute steps, and an add step too
// when a timeout ends the previous packet before the byte is stored; no new one is
// accepted before that. A packet drains with one buffer read and one output register
// load per byte. The buffer has two banks, so the front end keeps filling one while
// the other drains; it holds s_tready low while it works on a transaction and when
// the bank it would fill still holds a packet waiting to go out. Reset clears the
// configuration to its defaults and empties both banks. When the receiver holds
// m_tready low the output register holds its transaction and the drain waits.
`default_nettype none
module serial_packet_framer #(
	parameter int MAX_BYTES = spf_pkg::MAX_BYTES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// s_tdata fields from bit 0: data_byte[7:0], now_ms[39:8]
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [spf_pkg::IN_DATA_W-1:0]  s_tdata,
	// s_tuser fields from bit 0: op
	input  wire logic                           s_tuser,
	// m_tdata fields from bit 0: out_byte[7:0], packet_length[14:8], zero pad
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [spf_pkg::OUT_DATA_W-1:0]      m_tdata,
	output logic                                m_tlast,
	input  wire logic                           cfg_wr_en,
	input  wire logic [spf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [spf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import spf_pkg::*;

	push_t      push;
	wr_t        wr;
	logic [1:0] busy;

	// The front end owns one bank at a time and flips banks on every finished packet.
	spf_front #(.MAX_BYTES(MAX_BYTES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.busy      (busy),
		.push      (push),
		.wr        (wr)
	);

	// The drain releases a bank as soon as its last byte has been read.
	spf_back #(.MAX_BYTES(MAX_BYTES)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr       (wr),
		.busy     (busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

### rtl/spf_front.sv
// Front end: accepts items, holds configuration, fills the packet buffer and detects packet ends.
`default_nettype none
module spf_front #(
	parameter int MAX_BYTES = spf_pkg::MAX_BYTES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [spf_pkg::IN_DATA_W-1:0]  s_tdata,
	input  wire logic                           s_tuser,
	input  wire logic                           cfg_wr_en,
	input  wire logic [spf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [spf_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic [1:0]                     busy,
	output spf_pkg::push_t                      push,
	output spf_pkg::wr_t                        wr
);
	import spf_pkg::*;

	localparam int CNT_W = $clog2(MAX_BYTES + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_ADD  = 2'd2;

	logic [1:0]       state_q;
	logic [1:0]       mode_q;
	logic [15:0]      gap_q;
	logic [7:0]       delim_q;
	logic [5:0]       loff_q;
	logic [CNT_W-1:0] fill_q;
	logic [31:0]      last_q;
	logic [7:0]       len_byte_q;
	logic             wbank_q;

	logic             op_s1;
	logic [7:0]       byte_s1;
	logic [31:0]      now_s1;

	logic [31:0]      elapsed;
	logic             fill_nz;
	logic             in_exec;
	logic             poll_drain;
	logic             tmo_drain;
	logic             do_add;
	logic             is_full;
	logic [CNT_W-1:0] fill_inc;
	logic             pos_is_len;
	logic [7:0]       payload;
	logic [8:0]       target;
	logic             len_done;
	logic             add_drain;

	assign elapsed    = now_s1 - last_q;
	assign fill_nz    = (fill_q != '0);
	assign in_exec    = (state_q == ST_EXEC);
	assign poll_drain = in_exec && (op_s1 == OP_POLL) && fill_nz &&
	                    (mode_q == MODE_TIMEOUT) && (elapsed >= {16'd0, gap_q});
	assign tmo_drain  = in_exec && (op_s1 == OP_BYTE) && fill_nz &&
	                    (mode_q == MODE_TIMEOUT) && (elapsed > {16'd0, gap_q});
	assign do_add     = (in_exec && (op_s1 == OP_BYTE) && !tmo_drain) ||
	                    ((state_q == ST_ADD) && !busy[wbank_q]);
	assign is_full    = (fill_q == CNT_W'(MAX_BYTES));
	assign fill_inc   = fill_q + CNT_W'(1);
	assign pos_is_len = (LEN_W'(fill_q) == LEN_W'(loff_q));
	assign payload    = pos_is_len ? byte_s1 : len_byte_q;
	assign target     = 9'(loff_q) + 9'd1 + 9'(payload);
	assign len_done   = (9'(fill_inc) > 9'(loff_q)) && (payload != 8'd0) &&
	                    (9'(fill_inc) >= target);
	assign add_drain  = !is_full &&
	                    (((mode_q == MODE_DELIM) && (byte_s1 == delim_q)) ||
	                     ((mode_q == MODE_LENGTH) && len_done));

	always_comb begin
		push.valid = poll_drain || tmo_drain || (do_add && add_drain);
		push.bank  = wbank_q;
		push.len   = (do_add && add_drain) ? LEN_W'(fill_inc) : LEN_W'(fill_q);
		wr.en      = do_add && !is_full;
		wr.bank    = wbank_q;
		wr.idx     = PTR_W'(fill_q);
		wr.data    = byte_s1;
	end

	assign s_tready = (state_q == ST_IDLE) && !busy[wbank_q];

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= s_tuser;
			byte_s1 <= s_tdata[7:0];
			now_s1  <= s_tdata[39:8];
		end
		if (wr.en && pos_is_len) begin
			len_byte_q <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= MODE_TIMEOUT;
			gap_q   <= DEFAULT_GAP;
			delim_q <= 8'd0;
			loff_q  <= 6'd0;
			fill_q  <= '0;
			last_q  <= 32'd0;
			wbank_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MODE:   mode_q  <= cfg_wdata[1:0];
				REG_GAP:    gap_q   <= (cfg_wdata == 16'd0) ? DEFAULT_GAP : cfg_wdata;
				REG_DELIM:  delim_q <= cfg_wdata[7:0];
				REG_OFFSET: loff_q  <= cfg_wdata[5:0];
				default:    mode_q  <= mode_q;
			endcase
			fill_q <= '0;
			last_q <= 32'd0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tready) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (tmo_drain) begin
						state_q <= ST_ADD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_ADD: begin
					if (!busy[wbank_q]) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (push.valid) begin
				wbank_q <= !wbank_q;
			end

			if (do_add) begin
				if (is_full) begin
					fill_q <= '0;
					last_q <= now_s1;
				end else if (add_drain) begin
					fill_q <= '0;
					last_q <= 32'd0;
				end else begin
					fill_q <= fill_inc;
					last_q <= now_s1;
				end
			end else if (push.valid) begin
				fill_q <= '0;
				last_q <= 32'd0;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/spf_back.sv
// Back end: two-bank packet buffer and the drain that streams finished packets out.
`default_nettype none
module spf_back #(
	parameter int MAX_BYTES = spf_pkg::MAX_BYTES_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  spf_pkg::push_t                       push,
	input  spf_pkg::wr_t                         wr,
	output logic [1:0]                           busy,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [spf_pkg::OUT_DATA_W-1:0]       m_tdata,
	output logic                                 m_tlast
);
	import spf_pkg::*;

	localparam int IDX_W = $clog2(MAX_BYTES);
	localparam int CNT_W = $clog2(MAX_BYTES + 1);
	localparam int DEPTH = 2 ** (IDX_W + 1);

	logic [7:0]       mem [DEPTH];
	logic [1:0]       busy_q;
	logic [LEN_W-1:0] len_q [2];
	logic             rbank_q;
	logic [IDX_W-1:0] idx_q;

	logic             rd_s1;
	logic             last_s1;
	logic [LEN_W-1:0] plen_s1;
	logic [7:0]       rdata_s1;

	logic             ov_q;
	logic [7:0]       obyte_q;
	logic             olast_q;
	logic [LEN_W-1:0] olen_q;

	logic [CNT_W-1:0] cur_len;
	logic             issue;
	logic             is_last;

	assign cur_len = len_q[rbank_q][CNT_W-1:0];
	assign issue   = busy_q[rbank_q] && !rd_s1 && (!ov_q || m_tready);
	assign is_last = ((CNT_W'(idx_q) + CNT_W'(1)) == cur_len);
	assign busy    = busy_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[{wr.bank, wr.idx[IDX_W-1:0]}] <= wr.data;
		end
		if (issue) begin
			rdata_s1 <= mem[{rbank_q, idx_q}];
			last_s1  <= is_last;
			plen_s1  <= len_q[rbank_q];
		end
		if (push.valid) begin
			len_q[push.bank] <= push.len;
		end
		if (rd_s1) begin
			obyte_q <= rdata_s1;
			olast_q <= last_s1;
			olen_q  <= plen_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 2'b00;
			rbank_q <= 1'b0;
			idx_q   <= '0;
			rd_s1   <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			for (int b = 0; b < 2; b++) begin
				if (push.valid && (push.bank == 1'(b))) begin
					busy_q[b] <= 1'b1;
				end else if (issue && is_last && (rbank_q == 1'(b))) begin
					busy_q[b] <= 1'b0;
				end
			end
			if (issue) begin
				if (is_last) begin
					idx_q   <= '0;
					rbank_q <= !rbank_q;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
			rd_s1 <= issue;
			if (rd_s1) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = ov_q;
	assign m_tlast  = olast_q;
	assign m_tdata  = {1'b0, olen_q, obyte_q};

endmodule
`default_nettype wire

### rtl/spf_checker.sv
// Port-level assertions for the serial packet framer and their bind.
`default_nettype none
module spf_checker #(
	parameter int MAX_BYTES = spf_pkg::MAX_BYTES_DEF
) (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           s_tvalid,
	input wire logic                           s_tready,
	input wire logic [spf_pkg::IN_DATA_W-1:0]  s_tdata,
	input wire logic                           s_tuser,
	input wire logic                           m_tvalid,
	input wire logic                           m_tready,
	input wire logic [spf_pkg::OUT_DATA_W-1:0] m_tdata,
	input wire logic                           m_tlast
);
	import spf_pkg::*;

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
		else $error("input transaction changed while waiting");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output transaction changed while stalled");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[14:8] != 7'd0) && (m_tdata[14:8] <= 7'(MAX_BYTES)))
		else $error("packet length out of range");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("front end took a second item while busy");

	a_len_const: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast ##1 m_tvalid |-> $stable(m_tdata[14:8]))
		else $error("packet length changed inside a packet");

endmodule

bind serial_packet_framer spf_checker #(.MAX_BYTES(MAX_BYTES)) u_spf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
`default_nettype wire
